/* sv/bar_beat_tick_position_unit_macros.svh */
// assertion macros for the bar beat tick position unit
`ifndef BAR_BEAT_TICK_POSITION_UNIT_MACROS_SVH
`define BAR_BEAT_TICK_POSITION_UNIT_MACROS_SVH

// same-cycle implication
`define BBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BBT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bbt_pkg.sv */
// types and constants shared by the bar beat tick position unit
package bbt_pkg;

   localparam int DIV_WIDTH = 32;
   localparam int TPB_WIDTH = 16;
   localparam int BPB_WIDTH = 8;

   typedef enum logic [2:0] {
      CMD_TO_POS   = 3'd0,
      CMD_TO_TICKS = 3'd1,
      CMD_ADD      = 3'd2,
      CMD_NORM     = 3'd3,
      CMD_CMP      = 3'd4
   } cmd_type;

   localparam logic CSR_TPB = 1'b0;
   localparam logic CSR_BPB = 1'b1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [16:0] beat_sum;
      logic [24:0] bar_base;
      logic [23:0] a_bar;
      logic [15:0] a_beat;
      logic [31:0] a_unit;
      logic [31:0] ticks;
   } side1_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [24:0] bar_base;
      logic [23:0] a_bar;
      logic [15:0] a_beat;
      logic [31:0] a_unit;
      logic [31:0] ticks;
      logic [15:0] unit;
   } side2_type;

endpackage

/* sv/bbt_ifs.sv */
// channel interfaces of the bar beat tick position unit
interface bbt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] tick_count;
   logic [23:0] first_bar;
   logic [15:0] first_beat;
   logic [31:0] first_unit;
   logic [23:0] second_bar;
   logic [15:0] second_beat;
   logic [31:0] second_unit;
   modport source (output valid, cmd, tick_count, first_bar, first_beat, first_unit,
                   second_bar, second_beat, second_unit, input ready);
   modport sink (input valid, cmd, tick_count, first_bar, first_beat, first_unit,
                 second_bar, second_beat, second_unit, output ready);
endinterface

interface bbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] ticks_out;
   logic [23:0] bar_out;
   logic [7:0]  beat_out;
   logic [15:0] unit_out;
   logic        is_less;
   logic        is_equal;
   modport source (output valid, ticks_out, bar_out, beat_out, unit_out, is_less, is_equal,
                   input ready);
   modport sink (input valid, ticks_out, bar_out, beat_out, unit_out, is_less, is_equal,
                 output ready);
endinterface

interface bbt_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/bar_beat_tick_position_unit.sv */
// stages from request to response: front, 32 unit cells, middle, 32 beat cells,
// output register; throughput: one word per cycle unless stalled, the two chains of division
// cells retire one quotient bit per cell per cycle
// the whole pipe stalls only while the output register holds an untaken word
// reset: synchronous, clears all valid bits, ticks per beat to 480, beats per bar to 4
module bar_beat_tick_position_unit (
   input logic         clock,
   input logic         reset,
   bbt_req_if.sink     req_ch,
   bbt_rsp_if.source   rsp_ch,
   bbt_csr_if.sink     csr_ch
);
   import bbt_pkg::*;

   logic [TPB_WIDTH-1:0] tpb_ff, tpb_eff;
   logic [BPB_WIDTH-1:0] bpb_ff, bpb_eff;
   logic                 en;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff <= TPB_WIDTH'(480);
         bpb_ff <= BPB_WIDTH'(4);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TPB: tpb_ff <= csr_ch.data;
            CSR_BPB: bpb_ff <= csr_ch.data[BPB_WIDTH-1:0];
            default: tpb_ff <= tpb_ff;
         endcase
      end
   end
   assign csr_ch.ready = 1'b1;
   assign tpb_eff = (tpb_ff == '0) ? TPB_WIDTH'(1) : tpb_ff;
   assign bpb_eff = (bpb_ff == '0) ? BPB_WIDTH'(1) : bpb_ff;

   logic rsp_valid_ff;
   assign en = !(rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = en;

   // front stage
   logic        f0_valid_ff;
   logic [2:0]  f0_cmd_ff;
   logic [31:0] f0_d1_ff, f0_d1_in;
   logic [16:0] f0_beat_sum_ff, f0_beat_sum_in;
   logic [24:0] f0_bar_base_ff, f0_bar_base_in;
   logic [23:0] f0_a_bar_ff;
   logic [15:0] f0_a_beat_ff;
   logic [31:0] f0_a_unit_ff;
   logic [31:0] f0_p1_ff, f0_p2_ff;
   logic [39:0] p1_full;
   logic [31:0] p2_full;

   always_comb begin
      f0_d1_in       = '0;
      f0_beat_sum_in = '0;
      f0_bar_base_in = '0;
      unique case (req_ch.cmd)
         CMD_TO_POS: begin
            f0_d1_in = req_ch.tick_count;
         end
         CMD_ADD: begin
            f0_d1_in       = req_ch.first_unit + req_ch.second_unit;
            f0_beat_sum_in = {1'b0, req_ch.first_beat} + {1'b0, req_ch.second_beat};
            f0_bar_base_in = {1'b0, req_ch.first_bar} + {1'b0, req_ch.second_bar};
         end
         CMD_NORM: begin
            f0_d1_in       = req_ch.first_unit;
            f0_beat_sum_in = {1'b0, req_ch.first_beat};
            f0_bar_base_in = {1'b0, req_ch.first_bar};
         end
         CMD_CMP: begin
            f0_d1_in       = req_ch.second_unit;
            f0_beat_sum_in = {1'b0, req_ch.second_beat};
            f0_bar_base_in = {1'b0, req_ch.second_bar};
         end
         default: begin
            f0_d1_in = '0;
         end
      endcase
      p1_full = {16'b0, req_ch.first_bar} * {24'b0, tpb_eff};
      p2_full = {16'b0, req_ch.first_beat} * {16'b0, tpb_eff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
      end else if (en) begin
         f0_valid_ff <= req_ch.valid;
      end
      if (en) begin
         f0_cmd_ff      <= req_ch.cmd;
         f0_d1_ff       <= f0_d1_in;
         f0_beat_sum_ff <= f0_beat_sum_in;
         f0_bar_base_ff <= f0_bar_base_in;
         f0_a_bar_ff    <= req_ch.first_bar;
         f0_a_beat_ff   <= req_ch.first_beat;
         f0_a_unit_ff   <= req_ch.first_unit;
         f0_p1_ff       <= p1_full[31:0];
         f0_p2_ff       <= p2_full;
      end
   end

   // position to ticks
   side1_type   side1_in, side1_out;
   logic [39:0] p3_full;

   always_comb begin
      p3_full           = {8'b0, f0_p1_ff} * {32'b0, bpb_eff};
      side1_in.cmd      = f0_cmd_ff;
      side1_in.beat_sum = f0_beat_sum_ff;
      side1_in.bar_base = f0_bar_base_ff;
      side1_in.a_bar    = f0_a_bar_ff;
      side1_in.a_beat   = f0_a_beat_ff;
      side1_in.a_unit   = f0_a_unit_ff;
      side1_in.ticks    = p3_full[31:0] + f0_p2_ff + f0_a_unit_ff;
   end

   logic                 d1_valid;
   logic [31:0]          q1;
   logic [TPB_WIDTH-1:0] r1;

   bbt_div_chain #(.DW(TPB_WIDTH), .SW($bits(side1_type))) u_unit_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f0_valid_ff),
      .dividend  (f0_d1_ff),
      .in_side   (side1_in),
      .divisor   (tpb_eff),
      .out_valid (d1_valid),
      .quotient  (q1),
      .remainder (r1),
      .out_side  (side1_out)
   );

   // middle stage, beat carry
   logic        mid_valid_ff;
   logic [31:0] mid_d2_ff;
   side2_type   mid_side_ff, side2_in;

   always_comb begin
      side2_in.cmd      = side1_out.cmd;
      side2_in.bar_base = side1_out.bar_base;
      side2_in.a_bar    = side1_out.a_bar;
      side2_in.a_beat   = side1_out.a_beat;
      side2_in.a_unit   = side1_out.a_unit;
      side2_in.ticks    = side1_out.ticks;
      side2_in.unit     = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (en) begin
         mid_valid_ff <= d1_valid;
      end
      if (en) begin
         mid_d2_ff   <= q1 + {15'b0, side1_out.beat_sum};
         mid_side_ff <= side2_in;
      end
   end

   logic                 d2_valid;
   logic [31:0]          q2;
   logic [BPB_WIDTH-1:0] r2;
   side2_type            side2_out;

   bbt_div_chain #(.DW(BPB_WIDTH), .SW($bits(side2_type))) u_beat_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mid_valid_ff),
      .dividend  (mid_d2_ff),
      .in_side   (mid_side_ff),
      .divisor   (bpb_eff),
      .out_valid (d2_valid),
      .quotient  (q2),
      .remainder (r2),
      .out_side  (side2_out)
   );

   // result and compare
   logic [31:0] bar_full, a_bar32;
   logic        less, equal;
   logic [31:0] ticks_in;
   logic [23:0] bar_in;
   logic [7:0]  beat_in;
   logic [15:0] unit_in;
   logic        less_in, equal_in;

   always_comb begin
      bar_full = q2 + {7'b0, side2_out.bar_base};
      a_bar32  = {8'b0, side2_out.a_bar};
      if (a_bar32 != bar_full) begin
         less = a_bar32 < bar_full;
      end else if (side2_out.a_beat != {8'b0, r2}) begin
         less = side2_out.a_beat < {8'b0, r2};
      end else begin
         less = side2_out.a_unit < {16'b0, side2_out.unit};
      end
      equal = (a_bar32 == bar_full) && (side2_out.a_beat == {8'b0, r2}) &&
              (side2_out.a_unit == {16'b0, side2_out.unit});
      ticks_in = '0;
      bar_in   = '0;
      beat_in  = '0;
      unit_in  = '0;
      less_in  = 1'b0;
      equal_in = 1'b0;
      unique case (side2_out.cmd)
         CMD_TO_POS, CMD_ADD, CMD_NORM: begin
            bar_in  = bar_full[23:0];
            beat_in = r2;
            unit_in = side2_out.unit;
         end
         CMD_TO_TICKS: begin
            ticks_in = side2_out.ticks;
         end
         CMD_CMP: begin
            less_in  = less;
            equal_in = equal;
         end
         default: begin
            ticks_in = '0;
         end
      endcase
   end

   logic [31:0] ticks_ff;
   logic [23:0] bar_ff;
   logic [7:0]  beat_ff;
   logic [15:0] unit_ff;
   logic        less_ff, equal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d2_valid;
      end
      if (en) begin
         ticks_ff <= ticks_in;
         bar_ff   <= bar_in;
         beat_ff  <= beat_in;
         unit_ff  <= unit_in;
         less_ff  <= less_in;
         equal_ff <= equal_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.ticks_out = ticks_ff;
   assign rsp_ch.bar_out   = bar_ff;
   assign rsp_ch.beat_out  = beat_ff;
   assign rsp_ch.unit_out  = unit_ff;
   assign rsp_ch.is_less   = less_ff;
   assign rsp_ch.is_equal  = equal_ff;
endmodule

/* sv/bbt_div_cell.sv */
// one restoring division step, one quotient bit per cell
module bbt_div_cell #(
   parameter int DW = 16,
   parameter int SW = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [DW-1:0]                  in_rem,
   input  logic [bbt_pkg::DIV_WIDTH-1:0]  in_quo,
   input  logic [SW-1:0]                  in_side,
   input  logic [DW-1:0]                  divisor,
   output logic                           out_valid,
   output logic [DW-1:0]                  out_rem,
   output logic [bbt_pkg::DIV_WIDTH-1:0]  out_quo,
   output logic [SW-1:0]                  out_side
);
   import bbt_pkg::*;

   logic                 valid_ff;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [SW-1:0]        side_ff;
   logic [DW:0]          trial, diff;
   logic                 take;

   always_comb begin
      trial  = {in_rem, in_quo[DIV_WIDTH-1]};
      diff   = trial - {1'b0, divisor};
      take   = trial >= {1'b0, divisor};
      rem_in = take ? diff[DW-1:0] : trial[DW-1:0];
      quo_in = {in_quo[DIV_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;
endmodule

/* sv/bbt_div_chain.sv */
// row of division cells, a full quotient and remainder at the end
module bbt_div_chain #(
   parameter int DW = 16,
   parameter int SW = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [bbt_pkg::DIV_WIDTH-1:0]  dividend,
   input  logic [SW-1:0]                  in_side,
   input  logic [DW-1:0]                  divisor,
   output logic                           out_valid,
   output logic [bbt_pkg::DIV_WIDTH-1:0]  quotient,
   output logic [DW-1:0]                  remainder,
   output logic [SW-1:0]                  out_side
);
   import bbt_pkg::*;

   logic                 valid_l [0:DIV_WIDTH];
   logic [DW-1:0]        rem_l   [0:DIV_WIDTH];
   logic [DIV_WIDTH-1:0] quo_l   [0:DIV_WIDTH];
   logic [SW-1:0]        side_l  [0:DIV_WIDTH];

   assign valid_l[0] = in_valid;
   assign rem_l[0]   = '0;
   assign quo_l[0]   = dividend;
   assign side_l[0]  = in_side;

   for (genvar i = 0; i < DIV_WIDTH; i++) begin : g_cell
      bbt_div_cell #(.DW(DW), .SW(SW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_l[i]),
         .in_rem    (rem_l[i]),
         .in_quo    (quo_l[i]),
         .in_side   (side_l[i]),
         .divisor   (divisor),
         .out_valid (valid_l[i+1]),
         .out_rem   (rem_l[i+1]),
         .out_quo   (quo_l[i+1]),
         .out_side  (side_l[i+1])
      );
   end

   assign out_valid = valid_l[DIV_WIDTH];
   assign quotient  = quo_l[DIV_WIDTH];
   assign remainder = rem_l[DIV_WIDTH];
   assign out_side  = side_l[DIV_WIDTH];
endmodule

/* sv/bbt_checker.sv */
// port checks for the bar beat tick position unit and their bind
`include "bar_beat_tick_position_unit_macros.svh"

module bbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] ticks_out,
   input logic [23:0] bar_out,
   input logic [7:0]  beat_out,
   input logic [15:0] unit_out,
   input logic        is_less,
   input logic        is_equal
);
   `BBT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(ticks_out) && $stable(bar_out) && $stable(unit_out), "response word changed while stalled")
   `BBT_ASSERT_IMP(a_flags_excl, clock, reset, rsp_valid, !(is_less && is_equal), "less and equal both set")
   `BBT_ASSERT_IMP(a_cmp_only, clock, reset, rsp_valid && (is_less || is_equal), ticks_out == 0 && bar_out == 0 && beat_out == 0 && unit_out == 0, "compare word carries position data")
   `BBT_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid after reset")
endmodule

bind bar_beat_tick_position_unit bbt_checker u_bbt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .ticks_out (rsp_ch.ticks_out),
   .bar_out   (rsp_ch.bar_out),
   .beat_out  (rsp_ch.beat_out),
   .unit_out  (rsp_ch.unit_out),
   .is_less   (rsp_ch.is_less),
   .is_equal  (rsp_ch.is_equal)
);

/* bench/bbt_tb_ifs_note.sv */
`timescale 1ns / 1ps
// result word type used by the checker of the bar beat tick position unit
package bbt_tb_pkg;

   typedef struct packed {
      logic [31:0] ticks_out;
      logic [23:0] bar_out;
      logic [7:0]  beat_out;
      logic [15:0] unit_out;
      logic        is_less;
      logic        is_equal;
   } result_type;

endpackage

/* bench/bar_beat_tick_position_unit_checker.sv */
`timescale 1ns / 1ps
// checker: predicts every response word of the position unit and compares it
module bar_beat_tick_position_unit_checker
   import bbt_pkg::*;
   import bbt_tb_pkg::*;
(
   input logic      clock,
   input logic      reset,
   bbt_req_if.sink  req_mon,
   bbt_rsp_if.sink  rsp_mon,
   bbt_csr_if.sink  csr_mon,
   output int       fail_count,
   output int       pending
);

   logic [15:0] ticks_per_beat;
   logic [7:0]  beats_per_bar;
   result_type  expected_words[$];

   function automatic result_type predict_position(
      logic [2:0] cmd, logic [31:0] tick_count,
      logic [31:0] a_bar, logic [31:0] a_beat, logic [31:0] a_unit,
      logic [31:0] b_bar, logic [31:0] b_beat, logic [31:0] b_unit);
      logic [31:0] tpb, bpb, tpbar, rem, t, n_bar, n_beat, n_unit, r_bar, r_beat, r_unit;
      result_type w;
      tpb = (ticks_per_beat == 0) ? 32'd1 : {16'd0, ticks_per_beat};
      bpb = (beats_per_bar == 0) ? 32'd1 : {24'd0, beats_per_bar};
      tpbar = tpb * bpb;
      w = '0;
      r_bar = 0;
      r_beat = 0;
      r_unit = 0;
      case (cmd)
         CMD_TO_POS: begin
            rem = tick_count % tpbar;
            r_bar = tick_count / tpbar;
            r_beat = rem / tpb;
            r_unit = rem % tpb;
         end
         CMD_TO_TICKS: w.ticks_out = a_bar * tpbar + a_beat * tpb + a_unit;
         CMD_ADD: begin
            t = a_unit + b_unit;
            r_unit = t % tpb;
            t = a_beat + b_beat + t / tpb;
            r_beat = t % bpb;
            r_bar = a_bar + b_bar + t / bpb;
         end
         CMD_NORM: begin
            t = a_unit / tpb + a_beat;
            r_unit = a_unit % tpb;
            r_beat = t % bpb;
            r_bar = a_bar + t / bpb;
         end
         CMD_CMP: begin
            t = b_unit / tpb + b_beat;
            n_unit = b_unit % tpb;
            n_beat = t % bpb;
            n_bar = b_bar + t / bpb;
            if (a_bar != n_bar) w.is_less = a_bar < n_bar;
            else if (a_beat != n_beat) w.is_less = a_beat < n_beat;
            else w.is_less = a_unit < n_unit;
            w.is_equal = (a_bar == n_bar) && (a_beat == n_beat) && (a_unit == n_unit);
         end
         default: ;
      endcase
      w.bar_out = r_bar[23:0];
      w.beat_out = r_beat[7:0];
      w.unit_out = r_unit[15:0];
      return w;
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         ticks_per_beat <= 16'd480;
         beats_per_bar <= 8'd4;
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_TPB) ticks_per_beat <= csr_mon.data;
            else beats_per_bar <= csr_mon.data[7:0];
         end
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(predict_position(req_mon.cmd, req_mon.tick_count,
               {8'd0, req_mon.first_bar}, {16'd0, req_mon.first_beat}, req_mon.first_unit,
               {8'd0, req_mon.second_bar}, {16'd0, req_mon.second_beat},
               req_mon.second_unit));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.ticks_out, rsp_mon.bar_out, rsp_mon.beat_out, rsp_mon.unit_out,
                   rsp_mon.is_less, rsp_mon.is_equal};
            if (expected_words.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected word %h", got);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: ticks %h/%h bar %h/%h beat %h/%h unit %h/%h lt %b/%b eq %b/%b",
                        want.ticks_out, got.ticks_out, want.bar_out, got.bar_out,
                        want.beat_out, got.beat_out, want.unit_out, got.unit_out,
                        want.is_less, got.is_less, want.is_equal, got.is_equal);
               end
            end
         end
      end
      pending <= expected_words.size();
   end

endmodule

/* bench/bar_beat_tick_position_unit_tb.sv */
`timescale 1ns / 1ps
// testbench top: stimulus, configuration phases and verdict for the position unit
module bar_beat_tick_position_unit_tb;
   import bbt_pkg::*;

   localparam int LATENCY = 67;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   stall_phase = 0;

   bbt_req_if req_ch();
   bbt_rsp_if rsp_ch();
   bbt_csr_if csr_ch();

   bar_beat_tick_position_unit DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   bar_beat_tick_position_unit_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch), .csr_mon(csr_ch),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver stalls: alternating modes of free flow, random and long stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      stall_phase <= (stall_phase + 1) % 3000;
      if (stall_phase < 1000) rsp_ch.ready <= 1'b1;
      else if (stall_phase < 2000) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= ($urandom_range(0, 15) == 0);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL bar_beat_tick_position_unit");
         $finish;
      end
   end

   task automatic write_register(logic idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_word(logic [2:0] cmd, logic [31:0] ticks,
                            logic [23:0] a_bar, logic [15:0] a_beat, logic [31:0] a_unit,
                            logic [23:0] b_bar, logic [15:0] b_beat, logic [31:0] b_unit);
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.tick_count <= ticks;
      req_ch.first_bar <= a_bar;
      req_ch.first_beat <= a_beat;
      req_ch.first_unit <= a_unit;
      req_ch.second_bar <= b_bar;
      req_ch.second_beat <= b_beat;
      req_ch.second_unit <= b_unit;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_gap();
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 2000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      int burst;
      logic [2:0] cmd;
      logic [23:0] bar_a, bar_b;
      logic [15:0] beat_a, beat_b;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            if ($urandom_range(0, 1)) idle_gap();
            burst = $urandom_range(1, 40);
         end
         burst--;
         cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
         bar_a = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 50));
         bar_b = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 50));
         beat_a = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 9));
         beat_b = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 9));
         if (cmd == CMD_CMP && $urandom_range(0, 2) == 0) begin
            // compare against a copy of the first bar and beat to hit equality
            bar_b = bar_a;
            beat_b = beat_a;
            send_word(cmd, pick32(), bar_a, beat_a, pick32(), bar_b, beat_b,
                      $urandom_range(0, 3));
         end else begin
            send_word(cmd, pick32(), bar_a, beat_a, pick32(), bar_b, beat_b, pick32());
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.tick_count = '0;
      req_ch.first_bar = '0;
      req_ch.first_beat = '0;
      req_ch.first_unit = '0;
      req_ch.second_bar = '0;
      req_ch.second_beat = '0;
      req_ch.second_unit = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_TPB;
      csr_ch.data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings
      send_word(CMD_TO_POS, 32'd0, '0, '0, '0, '0, '0, '0);
      send_word(CMD_TO_POS, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
      send_word(CMD_TO_POS, 32'd1921, '0, '0, '0, '0, '0, '0);
      send_word(CMD_TO_TICKS, '0, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(CMD_TO_TICKS, '0, 24'd3, 16'd2, 32'd5, '0, '0, '0);
      send_word(CMD_ADD, '0, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(CMD_ADD, '0, 24'd1, 16'd3, 32'd479, 24'd0, 16'd0, 32'd1);
      send_word(CMD_NORM, '0, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(CMD_NORM, '0, 24'd2, 16'd7, 32'd1000, '0, '0, '0);
      send_word(CMD_CMP, '0, 24'd1, 16'd1, 32'd1, 24'd0, 16'd5, 32'd1);
      send_word(CMD_CMP, '0, 24'd1, 16'd1, 32'd1, 24'd1, 16'd1, 32'd2);
      send_word(CMD_CMP, '0, 24'd1, 16'd1, 32'd2, 24'd1, 16'd1, 32'd1);
      send_word(CMD_CMP, '0, 24'd1, 16'd0, 32'd0, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(CMD_CMP, '0, 24'hFF_FFFF, 16'd3, 32'd0, 24'hFF_FFFF, 16'd0, 32'd1440);
      send_word(3'd5, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(3'd7, 32'd9, 24'd1, 16'd1, 32'd1, 24'd1, 16'd1, 32'd1);
      random_phase(200);
      wait_drained();

      // zero divisors act as one
      write_register(CSR_TPB, 16'd0);
      write_register(CSR_BPB, 16'd0);
      random_phase(250);
      wait_drained();

      // largest divisors
      write_register(CSR_TPB, 16'hFFFF);
      write_register(CSR_BPB, 16'h00FF);
      random_phase(250);
      wait_drained();

      write_register(CSR_TPB, 16'd1);
      write_register(CSR_BPB, 16'hFF01);
      random_phase(250);
      wait_drained();

      for (int k = 0; k < 3; k++) begin
         write_register(CSR_TPB, 16'($urandom));
         write_register(CSR_BPB, 16'($urandom));
         random_phase(180);
         wait_drained();
      end

      if (fail_count == 0) $display("PASS bar_beat_tick_position_unit");
      else $display("FAIL bar_beat_tick_position_unit");
      $finish;
   end

endmodule
